### hdl/piecewise_linear_colormap_top_macros.svh
// Assertion macros for the color map block
`ifndef PIECEWISE_LINEAR_COLORMAP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_COLORMAP_TOP_MACROS_SVH

// same-cycle implication
`define PLCM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLCM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/plcm_pkg.sv
// Types, constants and stop table shared by the color map block
package plcm_pkg;

	localparam int CHANNEL_BITS    = 8;
	localparam int LEVEL_FRAC_BITS = 16;
	localparam int LEVEL_BITS      = LEVEL_FRAC_BITS + 2;
	localparam int STOP_BITS       = 16;
	localparam int STOP_W          = STOP_BITS + 1;
	localparam int QUARTER_SHIFT   = LEVEL_FRAC_BITS - 2;
	localparam int HALF_SHIFT      = LEVEL_FRAC_BITS - 1;
	localparam int CLAMP_W         = LEVEL_FRAC_BITS + 1;
	localparam int FRAC_W          = LEVEL_FRAC_BITS;
	localparam int DIFF_W          = STOP_W + 1;
	localparam int PROD_W          = DIFF_W + FRAC_W + 1;
	localparam int BLEND_W         = STOP_BITS + HALF_SHIFT + 1;
	localparam int SCALED_W        = BLEND_W + CHANNEL_BITS;
	localparam int NUM_CHANNELS    = 3;
	localparam int NUM_STOPS       = 5;
	localparam int NUM_TABLES      = 4;
	localparam int ROWS            = 16;
	localparam int ROW_ADDR_BITS   = 4;
	localparam int ROW_W           = 2 * NUM_CHANNELS * STOP_W;
	localparam int IN_TDATA_W      = ((LEVEL_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W     = ((NUM_CHANNELS * CHANNEL_BITS + 7) / 8) * 8;
	localparam int PADDR_W         = 3;

	localparam logic [CHANNEL_BITS-1:0] CMAX = '1;
	localparam logic [CLAMP_W-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	// register index of color_map
	localparam logic [0:0] REG_COLOR_MAP = 1'b0;

	typedef enum logic [2:0] {
		MAP_GRAY      = 3'd0,
		MAP_RAINBOW   = 3'd1,
		MAP_COOL_WARM = 3'd2,
		MAP_VIRIDIS   = 3'd3,
		MAP_PLASMA    = 3'd4
	} color_map_t;

	typedef enum logic [1:0] {
		SPAN_GRAY,
		SPAN_HALF,
		SPAN_QUARTER
	} span_t;

	// lookup stage payload
	typedef struct packed {
		logic [FRAC_W-1:0]  frac;
		logic [CLAMP_W-1:0] lvl;
		span_t              span;
	} lookup_t;

	// blend stage payload
	typedef struct packed {
		logic [NUM_CHANNELS-1:0][BLEND_W-1:0] chan;
		span_t                                span;
	} blend_t;

	// stops as 16-bit fractions: [table][stop][channel], tables rainbow, cool-warm,
	// viridis, plasma
	localparam logic [STOP_W-1:0] STOPS [NUM_TABLES][NUM_STOPS][NUM_CHANNELS] = '{
		'{ '{17'd0, 17'd0, 17'd65536}, '{17'd0, 17'd65536, 17'd0},
		   '{17'd65536, 17'd0, 17'd0}, '{17'd0, 17'd0, 17'd0}, '{17'd0, 17'd0, 17'd0} },
		'{ '{17'd0, 17'd0, 17'd65536}, '{17'd65536, 17'd65536, 17'd65536},
		   '{17'd65536, 17'd0, 17'd0}, '{17'd0, 17'd0, 17'd0}, '{17'd0, 17'd0, 17'd0} },
		'{ '{17'd17498, 17'd319, 17'd21589}, '{17'd15056, 17'd21126, 17'd35763},
		   '{17'd8360, 17'd37156, 17'd36081}, '{17'd24197, 17'd51701, 17'd25095},
		   '{17'd65094, 17'd59386, 17'd9433} },
		'{ '{17'd3302, 17'd1953, 17'd34601}, '{17'd32432, 17'd786, 17'd43114},
		   '{17'd52312, 17'd18363, 17'd30772}, '{17'd63794, 17'd38388, 17'd16485},
		   '{17'd61605, 17'd63908, 17'd8607} }
	};

	// one segment row: low stop in the lower half, high stop in the upper half
	function automatic logic [ROW_W-1:0] stop_row(input logic [ROW_ADDR_BITS-1:0] idx);
		logic [ROW_W-1:0] row;
		int               t;
		int               s;
		row = '0;
		t   = int'(idx[ROW_ADDR_BITS-1:2]);
		s   = int'(idx[1:0]);
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			row[ch*STOP_W +: STOP_W]                  = STOPS[t][s][ch];
			row[(NUM_CHANNELS+ch)*STOP_W +: STOP_W]   = STOPS[t][s+1][ch];
		end
		return row;
	endfunction

endpackage

### hdl/plcm_ram.sv
// Generic single-write, single-read RAM with registered read
module plcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/plcm_lookup.sv
// Table load, level clamp, segment select and stop row read
module plcm_lookup
	import plcm_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [2:0]                   color_map,
	input  logic                         in_valid,
	input  logic signed [LEVEL_BITS-1:0] in_level,
	output logic                         in_ready,
	input  logic                         out_free,
	output logic                         out_valid,
	output lookup_t                      out_data,
	output logic [ROW_W-1:0]             out_row,
	output logic                         init_done
);

	logic [ROW_ADDR_BITS:0]   init_q;
	logic                     valid_s1;
	lookup_t                  data_s1;
	logic                     s1_free;
	logic                     accept;
	logic [CLAMP_W-1:0]       lvl;
	logic [1:0]               seg;
	logic [1:0]               tbl;
	logic [CLAMP_W-1:0]       base;
	logic [CLAMP_W-1:0]       frac_full;
	span_t                    span;

	assign init_done = init_q[ROW_ADDR_BITS];

	// sweep the stop rows into the RAM after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
		end else if (!init_done) begin
			init_q <= init_q + 1'b1;
		end
	end

	assign s1_free  = !valid_s1 || out_free;
	assign in_ready = init_done && s1_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (in_level[LEVEL_BITS-1]) begin
			lvl = '0;
		end else if (in_level[LEVEL_BITS-2:0] > LEVEL_ONE) begin
			lvl = LEVEL_ONE;
		end else begin
			lvl = in_level[CLAMP_W-1:0];
		end
	end

	always_comb begin
		span = SPAN_GRAY;
		tbl  = 2'd0;
		seg  = 2'd0;
		base = '0;
		case (color_map)
			MAP_RAINBOW, MAP_COOL_WARM: begin
				span = SPAN_HALF;
				tbl  = (color_map == MAP_RAINBOW) ? 2'd0 : 2'd1;
				seg  = {1'b0, lvl[LEVEL_FRAC_BITS] | lvl[HALF_SHIFT]};
				base = CLAMP_W'(seg) << HALF_SHIFT;
			end
			MAP_VIRIDIS, MAP_PLASMA: begin
				span = SPAN_QUARTER;
				tbl  = (color_map == MAP_VIRIDIS) ? 2'd2 : 2'd3;
				seg  = lvl[LEVEL_FRAC_BITS] ? 2'd3 : lvl[HALF_SHIFT:QUARTER_SHIFT];
				base = CLAMP_W'(seg) << QUARTER_SHIFT;
			end
			default: begin
				span = SPAN_GRAY;
			end
		endcase
	end

	assign frac_full = lvl - base;

	plcm_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_stop_ram (
		.clk  (clk),
		.we   (!init_done),
		.waddr(init_q[ROW_ADDR_BITS-1:0]),
		.wdata(stop_row(init_q[ROW_ADDR_BITS-1:0])),
		.re   (accept),
		.raddr({tbl, seg}),
		.rdata(out_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.frac <= frac_full[FRAC_W-1:0];
			data_s1.lvl  <= lvl;
			data_s1.span <= span;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

### hdl/plcm_blend.sv
// Linear blend between the two stops of a segment, one multiply per channel
module plcm_blend
	import plcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  lookup_t          in_data,
	input  logic [ROW_W-1:0] in_row,
	output logic             in_free,
	input  logic             out_free,
	output logic             out_valid,
	output blend_t           out_data
);

	logic                     valid_s2;
	blend_t                   data_s2;
	logic                     s2_free;
	logic                     adv;
	blend_t                   blend;
	logic [STOP_W-1:0]        lo   [NUM_CHANNELS];
	logic [STOP_W-1:0]        hi   [NUM_CHANNELS];
	logic signed [DIFF_W-1:0] diff [NUM_CHANNELS];
	logic signed [PROD_W-1:0] prod [NUM_CHANNELS];
	logic [PROD_W-1:0]        base [NUM_CHANNELS];
	logic [PROD_W-1:0]        sum  [NUM_CHANNELS];

	assign s2_free = !valid_s2 || out_free;
	assign in_free = s2_free;
	assign adv     = in_valid && s2_free;

	always_comb begin
		blend.span = in_data.span;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			lo[ch]   = in_row[ch*STOP_W +: STOP_W];
			hi[ch]   = in_row[(NUM_CHANNELS+ch)*STOP_W +: STOP_W];
			diff[ch] = $signed({1'b0, hi[ch]}) - $signed({1'b0, lo[ch]});
			prod[ch] = diff[ch] * $signed({1'b0, in_data.frac});
			case (in_data.span)
				SPAN_HALF:    base[ch] = PROD_W'(lo[ch]) << HALF_SHIFT;
				SPAN_QUARTER: base[ch] = PROD_W'(lo[ch]) << QUARTER_SHIFT;
				default:      base[ch] = '0;
			endcase
			// a*2^S + (c-a)*f stays within 0..2^(16+S)
			sum[ch] = base[ch] + $unsigned(prod[ch]);
			if (in_data.span == SPAN_GRAY) begin
				blend.chan[ch] = BLEND_W'(in_data.lvl);
			end else begin
				blend.chan[ch] = sum[ch][BLEND_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= blend;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

### hdl/plcm_round.sv
// Scale to channel range, round half up, output register
module plcm_round
	import plcm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  blend_t                  in_data,
	output logic                    in_free,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CHANNEL_BITS-1:0] red,
	output logic [CHANNEL_BITS-1:0] green,
	output logic [CHANNEL_BITS-1:0] blue
);

	logic                                     out_valid_q;
	logic                                     out_free;
	logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan_q;
	logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan_d;
	logic [SCALED_W-1:0]                      scaled [NUM_CHANNELS];
	logic [SCALED_W-1:0]                      rounded [NUM_CHANNELS];

	assign out_free = !out_valid_q || out_ready;
	assign in_free  = out_free;

	always_comb begin
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			// v * CMAX as shift and subtract
			scaled[ch] = (SCALED_W'(in_data.chan[ch]) << CHANNEL_BITS)
				- SCALED_W'(in_data.chan[ch]);
			case (in_data.span)
				SPAN_HALF: rounded[ch] =
					(scaled[ch] + (SCALED_W'(1) << (STOP_BITS + HALF_SHIFT - 1)))
					>> (STOP_BITS + HALF_SHIFT);
				SPAN_QUARTER: rounded[ch] =
					(scaled[ch] + (SCALED_W'(1) << (STOP_BITS + QUARTER_SHIFT - 1)))
					>> (STOP_BITS + QUARTER_SHIFT);
				default: rounded[ch] =
					(scaled[ch] + (SCALED_W'(1) << (LEVEL_FRAC_BITS - 1)))
					>> LEVEL_FRAC_BITS;
			endcase
			if (rounded[ch] > SCALED_W'(CMAX)) begin
				chan_d[ch] = CMAX;
			end else begin
				chan_d[ch] = rounded[ch][CHANNEL_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && in_valid) begin
			chan_q <= chan_d;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = chan_q[0];
	assign green     = chan_q[1];
	assign blue      = chan_q[2];

endmodule

### hdl/piecewise_linear_colormap_top.sv
// Piecewise-linear color map: level in, RGB word out.
// s_axis carries one level word per handshake (signed, 1.0 = 65536, clamped to 0..1).
// m_axis carries one color word per accepted level, in order: red, green, blue.
// color_map sits at APB address 0: 0 gray, 1 rainbow, 2 cool-warm, 3 viridis,
// 4 plasma, 5..7 gray. Write it only while the pipeline is empty.
// A level accepted on s_axis passes the stop row read, the blend multiply, and the
// round and output register before it shows up on m_axis_tvalid.
// Throughput: one word per cycle while m_axis_tready stays high; the stop RAM has one
// read port and each level reads one segment row holding both of its stops.
// After reset the stop table is swept into the RAM, one row per cycle for all 16
// rows; s_axis_tready stays low until that is done.
// When the receiver stalls, each stage holds its word and bubbles are squeezed
// out; up to three words are held before s_axis_tready drops.
`include "piecewise_linear_colormap_top_macros.svh"

module piecewise_linear_colormap_top
	import plcm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// APB configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// level in
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // level[17:0], zero pad
	// color out
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

	logic [2:0]              color_map_q;
	logic                    reg_hit;
	logic                    init_done;
	logic                    valid_s1;
	lookup_t                 data_s1;
	logic [ROW_W-1:0]        row_s1;
	logic                    s2_free;
	logic                    valid_s2;
	blend_t                  data_s2;
	logic                    out_free;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_COLOR_MAP);
	assign prdata  = reg_hit ? {29'd0, color_map_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_map_q <= MAP_GRAY;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			color_map_q <= pwdata[2:0];
		end
	end

	plcm_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.color_map(color_map_q),
		.in_valid (s_axis_tvalid),
		.in_level ($signed(s_axis_tdata[LEVEL_BITS-1:0])),
		.in_ready (s_axis_tready),
		.out_free (s2_free),
		.out_valid(valid_s1),
		.out_data (data_s1),
		.out_row  (row_s1),
		.init_done(init_done)
	);

	plcm_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_data  (data_s1),
		.in_row   (row_s1),
		.in_free  (s2_free),
		.out_free (out_free),
		.out_valid(valid_s2),
		.out_data (data_s2)
	);

	plcm_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_data  (data_s2),
		.in_free  (out_free),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	assign m_axis_tdata = OUT_TDATA_W'({blue, green, red});

	`PLCM_ASSERT_SAME(a_ready_after_load, s_axis_tready, init_done, "input ready during table load")
	`PLCM_ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, valid_s1, "accepted word lost before lookup stage")
	`PLCM_ASSERT_NEXT(a_load_stays_done, init_done, init_done, "table load restarted")

endmodule

### tb/sv/piecewise_linear_colormap_top_tb.sv
// Testbench for piecewise_linear_colormap_top: levels in, RGB words checked against a predictor
module piecewise_linear_colormap_top_tb
	import plcm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] MAP_UNUSED_LO = 3'd5;
	localparam logic [2:0] MAP_UNUSED_HI = 3'd7;
	localparam int REG_UNUSED = 1;
	localparam longint LEVEL_UNITY = longint'(1) << LEVEL_FRAC_BITS;
	localparam longint CHAN_FULL = (longint'(1) << CHANNEL_BITS) - 1;
	localparam int SHIFT_QUARTER = LEVEL_FRAC_BITS - 2;
	localparam int SHIFT_HALF = LEVEL_FRAC_BITS - 1;
	localparam int FRAC16 = 16;
	localparam int WORDS_PER_CHUNK = 70;

	// color stops as 16-bit fractions: [rainbow..plasma][stop][r,g,b]
	localparam int COLOR_STOPS [4][5][3] = '{
		'{ '{0, 0, 65536}, '{0, 65536, 0}, '{65536, 0, 0}, '{0, 0, 0}, '{0, 0, 0} },
		'{ '{0, 0, 65536}, '{65536, 65536, 65536}, '{65536, 0, 0}, '{0, 0, 0},
		   '{0, 0, 0} },
		'{ '{17498, 319, 21589}, '{15056, 21126, 35763}, '{8360, 37156, 36081},
		   '{24197, 51701, 25095}, '{65094, 59386, 9433} },
		'{ '{3302, 1953, 34601}, '{32432, 786, 43114}, '{52312, 18363, 30772},
		   '{63794, 38388, 16485}, '{61605, 63908, 8607} }
	};

	// three levels per preset, preset order 0..7
	localparam logic [LEVEL_BITS-1:0] DIRECTED_LEVELS [24] = '{
		18'h3FFFF, 18'd0, 18'd65536,
		18'd0, 18'd32768, 18'd65535,
		18'd32767, 18'd32769, 18'd65537,
		18'd16384, 18'd49152, 18'h1FFFF,
		18'h20000, 18'd24576, 18'd57344,
		18'd1, 18'd32768, 18'd65536,
		18'd16383, 18'd40000, 18'h1FFFF,
		18'h20000, 18'd8191, 18'd65536
	};

	localparam logic [2:0] CHUNK_MAPS [12] = '{
		MAP_VIRIDIS, MAP_PLASMA, MAP_GRAY, MAP_RAINBOW,
		MAP_COOL_WARM, MAP_UNUSED_HI, MAP_PLASMA, MAP_VIRIDIS,
		MAP_UNUSED_LO, MAP_RAINBOW, MAP_COOL_WARM, MAP_VIRIDIS
	};

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] blue;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] red;
	} rgb_t;

	class colormap_checker;
		logic [2:0] map_sel;
		rgb_t       pending_colors[$];
		int         errors;

		function new();
			map_sel = MAP_GRAY;
			errors = 0;
		endfunction

		function longint to_chan(longint v, int frac_bits);
			longint r;
			r = (v * CHAN_FULL + (longint'(1) << (frac_bits - 1))) >> frac_bits;
			return (r > CHAN_FULL) ? CHAN_FULL : r;
		endfunction

		function rgb_t color_of_level(logic [LEVEL_BITS-1:0] raw);
			longint t, seg, f, a, c, v;
			longint chan[3];
			int     sh, last, tbl;
			rgb_t   rgb;
			t = longint'($signed(raw));
			if (t < 0)
				t = 0;
			if (t > LEVEL_UNITY)
				t = LEVEL_UNITY;
			if (map_sel == MAP_GRAY || map_sel > MAP_PLASMA) begin
				v = to_chan(t, LEVEL_FRAC_BITS);
				for (int ch = 0; ch < 3; ch++)
					chan[ch] = v;
			end else begin
				sh = (map_sel >= MAP_VIRIDIS) ? SHIFT_QUARTER : SHIFT_HALF;
				last = (map_sel >= MAP_VIRIDIS) ? 3 : 1;
				tbl = int'(map_sel) - int'(MAP_RAINBOW);
				seg = t >> sh;
				if (seg > last)
					seg = last;
				f = t - (seg << sh);
				for (int ch = 0; ch < 3; ch++) begin
					a = COLOR_STOPS[tbl][seg][ch];
					c = COLOR_STOPS[tbl][seg + 1][ch];
					v = (a << sh) + (c - a) * f;
					if (v < 0)
						v = 0;
					chan[ch] = to_chan(v, FRAC16 + sh);
				end
			end
			rgb.red = chan[0][CHANNEL_BITS-1:0];
			rgb.green = chan[1][CHANNEL_BITS-1:0];
			rgb.blue = chan[2][CHANNEL_BITS-1:0];
			return rgb;
		endfunction

		function void note_level(logic [LEVEL_BITS-1:0] raw);
			pending_colors.push_back(color_of_level(raw));
		endfunction

		function void check_color(logic [OUT_TDATA_W-1:0] word);
			rgb_t want, got;
			if (pending_colors.size() == 0) begin
				$error("unexpected color word %h", word);
				errors++;
				return;
			end
			want = pending_colors.pop_front();
			got = rgb_t'(word[3*CHANNEL_BITS-1:0]);
			if (got.red !== want.red) begin
				$error("red mismatch: expected %0d, actual %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("green mismatch: expected %0d, actual %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
				errors++;
			end
		endfunction

		function int pending();
			return pending_colors.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // level[17:0], zero pad
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // red[7:0], green[15:8], blue[23:16]

	colormap_checker sb;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_left = 0;

	piecewise_linear_colormap_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stalls plus one long hold-off
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_level(s_axis_tdata[LEVEL_BITS-1:0]);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_color(m_axis_tdata);
		end
	end

	task automatic send_level(input logic [LEVEL_BITS-1:0] lvl);
		int gap;
		if ($urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = IN_TDATA_W'(lvl);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic apb_write(input int idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = PADDR_W'(4 * idx);
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == int'(REG_COLOR_MAP))
			sb.map_sel = val[2:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apb_check_map();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = PADDR_W'(4 * int'(REG_COLOR_MAP));
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(sb.map_sel)) begin
			$error("color_map readback mismatch: expected %0d, actual %0d",
				sb.map_sel, prdata);
			sb.errors++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// drain the pipeline before touching the register
	task automatic set_color_map(input logic [2:0] map);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		apb_write(int'(REG_COLOR_MAP), {$urandom} & ~32'h7 | 32'(map));
		apb_check_map();
	endtask

	function automatic logic [LEVEL_BITS-1:0] random_level();
		int pick;
		pick = $urandom_range(99);
		if (pick < 75)
			return LEVEL_BITS'($urandom_range(65536));
		else if (pick < 85)
			return LEVEL_BITS'(16384 * $urandom_range(4));
		else
			return LEVEL_BITS'($urandom);
	endfunction

	initial begin
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// write to an unmapped register must not change the preset
		apb_write(REG_UNUSED, $urandom);
		apb_check_map();

		for (int m = 0; m < 8; m++) begin
			set_color_map(3'(m));
			for (int k = 0; k < 3; k++)
				send_level(DIRECTED_LEVELS[m * 3 + k]);
		end

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 66 : 0;
			rx_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 34 : 0;
			for (int chunk = 0; chunk < 4; chunk++) begin
				if (phase == 1 && chunk == 0) begin
					@(negedge clk);
					s_axis_tvalid = 1'b0;
					while (sb.pending() != 0)
						@(posedge clk);
					repeat (4) @(posedge clk);
					apb_write(REG_UNUSED, $urandom);
				end
				set_color_map(CHUNK_MAPS[phase * 4 + chunk]);
				// long receiver hold-off while levels keep coming
				if (phase == 2 && chunk == 1)
					hold_left = 60;
				for (int n = 0; n < WORDS_PER_CHUNK; n++)
					send_level(random_level());
			end
		end

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/plcm_pkg.sv
hdl/plcm_ram.sv
hdl/plcm_lookup.sv
hdl/plcm_blend.sv
hdl/plcm_round.sv
hdl/piecewise_linear_colormap_top.sv
tb/sv/piecewise_linear_colormap_top_tb.sv
